[design/uep_pkg.sv]
// Shared types, codes and constants of the serial EEPROM page protocol engine.
`default_nettype none

package uep_pkg;

    localparam int MEM_ADDR_BITS_DEF = 13;
    localparam int PAGE_BYTES        = 128;
    localparam int PAGE_IDX_W        = $clog2(PAGE_BYTES);
    localparam int BLOCK_BYTES       = 4096;
    localparam int BLOCK_SHIFT       = $clog2(BLOCK_BYTES);
    localparam int REMAIN_W          = 13;
    localparam int BASE_W            = 40;

    localparam logic [7:0] OP_PING1      = 8'h01;
    localparam logic [7:0] OP_PING2      = 8'h02;
    localparam logic [7:0] OP_BLOCK_READ = 8'h10;
    localparam logic [7:0] OP_PAGE_READ  = 8'h30;
    localparam logic [7:0] OP_PAGE_WRITE = 8'h40;
    localparam logic [7:0] OP_WRITE_NAK  = 8'h41;
    localparam logic [7:0] OP_RESET      = 8'h50;
    localparam logic [7:0] OP_BAUD       = 8'h7f;

    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_TX_PULL = 1'b1;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_BAUD  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [31:0] baud_value;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BLK_LO,
        ST_BLK_HI,
        ST_PAGE_LO,
        ST_PAGE_HI,
        ST_WR_LO,
        ST_WR_HI,
        ST_WR_DATA,
        ST_WR_SUM,
        ST_BAUD0,
        ST_BAUD1,
        ST_BAUD2,
        ST_BAUD3,
        ST_SEND,
        ST_SEND_WAIT,
        ST_COPY
    } state_t;

    typedef enum logic [3:0] {
        EM_NONE,
        EM_ECHO,
        EM_HDR_BLK,
        EM_HDR_PAGE,
        EM_ACK,
        EM_NAK,
        EM_BAUD,
        EM_RESET,
        EM_SUM,
        EM_DATA
    } emit_t;

    typedef struct packed {
        logic       addr_lo_ld;
        logic       addr_hi_ld;
        logic       blk_start;
        logic       page_start;
        logic       wr_start;
        logic       wr_byte;
        logic       baud_ld;
        logic [1:0] baud_idx;
        logic       rd_issue;
        logic       rd_take;
        logic       copy_start;
        logic       copy_run;
        emit_t      emit;
    } dp_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic fill_last;
        logic sum_match;
        logic copy_done;
    } dp_stat_t;

endpackage

`default_nettype wire

[design/uep_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module uep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/uep_out_buf.sv]
// Two-entry response buffer: output register plus skid register.
`default_nettype none

module uep_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire uep_pkg::rsp_t push_data,
    output logic               skid_full,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output uep_pkg::rsp_t      rsp
);

    logic          out_valid_reg;
    logic          out_valid_next;
    uep_pkg::rsp_t out_data_reg;
    uep_pkg::rsp_t out_data_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    uep_pkg::rsp_t skid_data_reg;
    uep_pkg::rsp_t skid_data_next;
    logic          take;

    assign take      = out_valid_reg && !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;
    assign skid_full = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

[design/uep_ctrl.sv]
// Command phase state machine that sequences the protocol datapath.
`default_nettype none

module uep_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire uep_pkg::req_t     req,
    output logic                   req_stall,
    input  wire logic              skid_full,
    input  wire uep_pkg::dp_stat_t stat,
    output uep_pkg::dp_cmd_t       cmd
);

    uep_pkg::state_t state_reg;
    uep_pkg::state_t state_next;
    logic            accepting;
    logic            acc;
    logic            pull;

    assign accepting = !(state_reg inside {uep_pkg::ST_SEND_WAIT, uep_pkg::ST_COPY})
                       && !skid_full;
    assign req_stall = !accepting;
    assign acc       = req_valid && accepting;
    assign pull      = (req.cmd == uep_pkg::CMD_TX_PULL);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uep_pkg::ST_SEND_WAIT:
            begin
                state_next = uep_pkg::ST_SEND;
            end
            uep_pkg::ST_COPY:
            begin
                if (stat.copy_done)
                begin
                    state_next = uep_pkg::ST_IDLE;
                end
            end
            uep_pkg::ST_SEND:
            begin
                if (acc && pull)
                begin
                    state_next = stat.rem_zero ? uep_pkg::ST_IDLE : uep_pkg::ST_SEND_WAIT;
                end
            end
            default:
            begin
                if (acc && !pull)
                begin
                    case (state_reg)
                        uep_pkg::ST_IDLE:
                        begin
                            case (req.rx_byte)
                                uep_pkg::OP_BLOCK_READ: state_next = uep_pkg::ST_BLK_LO;
                                uep_pkg::OP_PAGE_READ:  state_next = uep_pkg::ST_PAGE_LO;
                                uep_pkg::OP_PAGE_WRITE: state_next = uep_pkg::ST_WR_LO;
                                uep_pkg::OP_BAUD:       state_next = uep_pkg::ST_BAUD0;
                                default:                state_next = uep_pkg::ST_IDLE;
                            endcase
                        end
                        uep_pkg::ST_BLK_LO:  state_next = uep_pkg::ST_BLK_HI;
                        uep_pkg::ST_BLK_HI:  state_next = uep_pkg::ST_SEND;
                        uep_pkg::ST_PAGE_LO: state_next = uep_pkg::ST_PAGE_HI;
                        uep_pkg::ST_PAGE_HI: state_next = uep_pkg::ST_SEND;
                        uep_pkg::ST_WR_LO:   state_next = uep_pkg::ST_WR_HI;
                        uep_pkg::ST_WR_HI:   state_next = uep_pkg::ST_WR_DATA;
                        uep_pkg::ST_WR_DATA:
                        begin
                            if (stat.fill_last)
                            begin
                                state_next = uep_pkg::ST_WR_SUM;
                            end
                        end
                        uep_pkg::ST_WR_SUM:
                        begin
                            state_next = stat.sum_match ? uep_pkg::ST_COPY : uep_pkg::ST_IDLE;
                        end
                        uep_pkg::ST_BAUD0: state_next = uep_pkg::ST_BAUD1;
                        uep_pkg::ST_BAUD1: state_next = uep_pkg::ST_BAUD2;
                        uep_pkg::ST_BAUD2: state_next = uep_pkg::ST_BAUD3;
                        uep_pkg::ST_BAUD3: state_next = uep_pkg::ST_IDLE;
                        default:           state_next = uep_pkg::ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.emit = uep_pkg::EM_NONE;
        case (state_reg)
            uep_pkg::ST_SEND_WAIT:
            begin
                cmd.rd_take = 1'b1;
                cmd.emit    = uep_pkg::EM_DATA;
            end
            uep_pkg::ST_COPY:
            begin
                cmd.copy_run = 1'b1;
            end
            uep_pkg::ST_SEND:
            begin
                if (acc && pull)
                begin
                    if (stat.rem_zero)
                    begin
                        cmd.emit = uep_pkg::EM_SUM;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                    end
                end
            end
            default:
            begin
                if (acc && !pull)
                begin
                    case (state_reg)
                        uep_pkg::ST_IDLE:
                        begin
                            case (req.rx_byte)
                                uep_pkg::OP_PING1: cmd.emit = uep_pkg::EM_ECHO;
                                uep_pkg::OP_PING2: cmd.emit = uep_pkg::EM_ECHO;
                                uep_pkg::OP_RESET: cmd.emit = uep_pkg::EM_RESET;
                                default:           cmd.emit = uep_pkg::EM_NONE;
                            endcase
                        end
                        uep_pkg::ST_BLK_LO, uep_pkg::ST_PAGE_LO, uep_pkg::ST_WR_LO:
                        begin
                            cmd.addr_lo_ld = 1'b1;
                        end
                        uep_pkg::ST_BLK_HI:
                        begin
                            cmd.addr_hi_ld = 1'b1;
                            cmd.blk_start  = 1'b1;
                            cmd.emit       = uep_pkg::EM_HDR_BLK;
                        end
                        uep_pkg::ST_PAGE_HI:
                        begin
                            cmd.addr_hi_ld = 1'b1;
                            cmd.page_start = 1'b1;
                            cmd.emit       = uep_pkg::EM_HDR_PAGE;
                        end
                        uep_pkg::ST_WR_HI:
                        begin
                            cmd.addr_hi_ld = 1'b1;
                            cmd.wr_start   = 1'b1;
                        end
                        uep_pkg::ST_WR_DATA:
                        begin
                            cmd.wr_byte = 1'b1;
                        end
                        uep_pkg::ST_WR_SUM:
                        begin
                            if (stat.sum_match)
                            begin
                                cmd.copy_start = 1'b1;
                                cmd.emit       = uep_pkg::EM_ACK;
                            end
                            else
                            begin
                                cmd.emit = uep_pkg::EM_NAK;
                            end
                        end
                        uep_pkg::ST_BAUD0:
                        begin
                            cmd.baud_ld  = 1'b1;
                            cmd.baud_idx = 2'd0;
                        end
                        uep_pkg::ST_BAUD1:
                        begin
                            cmd.baud_ld  = 1'b1;
                            cmd.baud_idx = 2'd1;
                        end
                        uep_pkg::ST_BAUD2:
                        begin
                            cmd.baud_ld  = 1'b1;
                            cmd.baud_idx = 2'd2;
                        end
                        uep_pkg::ST_BAUD3:
                        begin
                            cmd.baud_ld  = 1'b1;
                            cmd.baud_idx = 2'd3;
                            cmd.emit     = uep_pkg::EM_BAUD;
                        end
                        default:
                        begin
                            cmd.emit = uep_pkg::EM_NONE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uep_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/uep_dp.sv]
// Protocol datapath: address, checksum, counters, page buffer, byte memory and response mux.
`default_nettype none

module uep_dp #(
    parameter int MEM_ADDR_BITS = uep_pkg::MEM_ADDR_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       rx_byte,
    input  wire uep_pkg::dp_cmd_t cmd,
    output uep_pkg::dp_stat_t     stat,
    output logic                  push,
    output uep_pkg::rsp_t         push_data
);

    localparam int MEM_DEPTH = 2 ** MEM_ADDR_BITS;
    localparam int IDX_W     = uep_pkg::PAGE_IDX_W;
    localparam int CNT_W     = IDX_W + 1;

    logic [15:0]                  addr_reg;
    logic [15:0]                  addr_next;
    logic [7:0]                   sum_reg;
    logic [7:0]                   sum_next;
    logic [CNT_W-1:0]             fill_reg;
    logic [CNT_W-1:0]             fill_next;
    logic [31:0]                  baud_reg;
    logic [31:0]                  baud_next;
    logic [MEM_ADDR_BITS-1:0]     ptr_reg;
    logic [MEM_ADDR_BITS-1:0]     ptr_next;
    logic [uep_pkg::REMAIN_W-1:0] rem_reg;
    logic [uep_pkg::REMAIN_W-1:0] rem_next;
    logic [CNT_W-1:0]             cp_cnt_reg;
    logic [CNT_W-1:0]             cp_cnt_next;
    logic                         cp_wr_reg;
    logic                         cp_wr_next;
    logic [IDX_W-1:0]             cp_idx_reg;
    logic [IDX_W-1:0]             cp_idx_next;

    logic [15:0]                  addr_new;
    logic [uep_pkg::BASE_W-1:0]   blk_base;
    logic [uep_pkg::BASE_W-1:0]   rd_page_base;
    logic [uep_pkg::BASE_W-1:0]   wr_page_base;
    logic                         cp_reading;
    logic [MEM_ADDR_BITS-1:0]     mem_waddr;
    logic [7:0]                   mem_rdata;
    logic [7:0]                   buf_rdata;

    assign addr_new     = {rx_byte, addr_reg[7:0]};
    assign blk_base     = uep_pkg::BASE_W'({addr_new, {uep_pkg::BLOCK_SHIFT{1'b0}}});
    assign rd_page_base = uep_pkg::BASE_W'({addr_new, {IDX_W{1'b0}}});
    assign wr_page_base = uep_pkg::BASE_W'({addr_reg, {IDX_W{1'b0}}});
    assign cp_reading   = cmd.copy_run && !cp_cnt_reg[CNT_W-1];
    assign mem_waddr    = wr_page_base[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(cp_idx_reg);

    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.fill_last = (fill_reg == CNT_W'(uep_pkg::PAGE_BYTES - 1));
    assign stat.sum_match = (rx_byte == sum_reg);
    assign stat.copy_done = cp_cnt_reg[CNT_W-1] && !cp_wr_reg;

    always_comb
    begin
        addr_next   = addr_reg;
        sum_next    = sum_reg;
        fill_next   = fill_reg;
        baud_next   = baud_reg;
        ptr_next    = ptr_reg;
        rem_next    = rem_reg;
        cp_cnt_next = cp_cnt_reg;
        cp_wr_next  = 1'b0;
        cp_idx_next = cp_idx_reg;

        if (cmd.addr_lo_ld)
        begin
            addr_next[7:0] = rx_byte;
        end
        if (cmd.addr_hi_ld)
        begin
            addr_next[15:8] = rx_byte;
        end
        if (cmd.blk_start)
        begin
            ptr_next = blk_base[MEM_ADDR_BITS-1:0];
            rem_next = uep_pkg::REMAIN_W'(uep_pkg::BLOCK_BYTES);
            sum_next = '0;
        end
        if (cmd.page_start)
        begin
            ptr_next = rd_page_base[MEM_ADDR_BITS-1:0];
            rem_next = uep_pkg::REMAIN_W'(uep_pkg::PAGE_BYTES);
            sum_next = '0;
        end
        if (cmd.wr_start)
        begin
            sum_next  = '0;
            fill_next = '0;
        end
        if (cmd.wr_byte)
        begin
            sum_next  = sum_reg + rx_byte;
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.baud_ld)
        begin
            baud_next[cmd.baud_idx*8 +: 8] = rx_byte;
        end
        if (cmd.rd_issue)
        begin
            ptr_next = ptr_reg + MEM_ADDR_BITS'(1);
            rem_next = rem_reg - uep_pkg::REMAIN_W'(1);
        end
        if (cmd.rd_take)
        begin
            sum_next = sum_reg + mem_rdata;
        end
        if (cmd.copy_start)
        begin
            cp_cnt_next = '0;
        end
        if (cp_reading)
        begin
            cp_cnt_next = cp_cnt_reg + CNT_W'(1);
            cp_wr_next  = 1'b1;
            cp_idx_next = cp_cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            sum_reg    <= '0;
            fill_reg   <= '0;
            baud_reg   <= '0;
            ptr_reg    <= '0;
            rem_reg    <= '0;
            cp_cnt_reg <= '0;
            cp_wr_reg  <= 1'b0;
            cp_idx_reg <= '0;
        end
        else
        begin
            addr_reg   <= addr_next;
            sum_reg    <= sum_next;
            fill_reg   <= fill_next;
            baud_reg   <= baud_next;
            ptr_reg    <= ptr_next;
            rem_reg    <= rem_next;
            cp_cnt_reg <= cp_cnt_next;
            cp_wr_reg  <= cp_wr_next;
            cp_idx_reg <= cp_idx_next;
        end
    end

    uep_ram #(
        .WIDTH (8),
        .DEPTH (uep_pkg::PAGE_BYTES)
    ) u_page_buf (
        .clk   (clk),
        .we    (cmd.wr_byte),
        .waddr (fill_reg[IDX_W-1:0]),
        .wdata (rx_byte),
        .re    (cp_reading),
        .raddr (cp_cnt_reg[IDX_W-1:0]),
        .rdata (buf_rdata)
    );

    uep_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_byte_mem (
        .clk   (clk),
        .we    (cp_wr_reg),
        .waddr (mem_waddr),
        .wdata (buf_rdata),
        .re    (cmd.rd_issue),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        push      = (cmd.emit != uep_pkg::EM_NONE);
        push_data = '0;
        case (cmd.emit)
            uep_pkg::EM_ECHO:
            begin
                push_data.kind    = uep_pkg::KIND_BYTE;
                push_data.tx_byte = rx_byte;
            end
            uep_pkg::EM_HDR_BLK:
            begin
                push_data.kind    = uep_pkg::KIND_BYTE;
                push_data.tx_byte = uep_pkg::OP_BLOCK_READ;
            end
            uep_pkg::EM_HDR_PAGE:
            begin
                push_data.kind    = uep_pkg::KIND_BYTE;
                push_data.tx_byte = uep_pkg::OP_PAGE_READ;
            end
            uep_pkg::EM_ACK:
            begin
                push_data.kind    = uep_pkg::KIND_BYTE;
                push_data.tx_byte = uep_pkg::OP_PAGE_WRITE;
            end
            uep_pkg::EM_NAK:
            begin
                push_data.kind    = uep_pkg::KIND_BYTE;
                push_data.tx_byte = uep_pkg::OP_WRITE_NAK;
            end
            uep_pkg::EM_BAUD:
            begin
                push_data.kind       = uep_pkg::KIND_BAUD;
                push_data.baud_value = {rx_byte, baud_reg[23:0]};
            end
            uep_pkg::EM_RESET:
            begin
                push_data.kind = uep_pkg::KIND_RESET;
            end
            uep_pkg::EM_SUM:
            begin
                push_data.kind    = uep_pkg::KIND_BYTE;
                push_data.tx_byte = sum_reg;
            end
            uep_pkg::EM_DATA:
            begin
                push_data.kind    = uep_pkg::KIND_BYTE;
                push_data.tx_byte = mem_rdata;
            end
            default:
            begin
                push_data = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/uart_eeprom_page_protocol.sv]
// Top level of the serial EEPROM page protocol engine.
//
//  Channel | Direction | Handshake            | Transaction contents
//  --------+-----------+----------------------+------------------------------------
//  req     | in        | req_valid, req_stall | cmd, rx_byte
//  rsp     | out       | rsp_valid, rsp_stall | kind, tx_byte, baud_value
//
// A received byte or an idle pull is accepted while req_stall is low; its response, if any,
// is registered in the output buffer.
// A data pull passes through ST_SEND_WAIT for the registered read of the byte memory.
// An acknowledged page write then copies the page buffer into memory one byte a cycle,
// with req_stall high.
// req_stall is also high while the skid register holds a response; no clearing pass
// follows reset.
`default_nettype none

module uart_eeprom_page_protocol #(
    parameter int MEM_ADDR_BITS = uep_pkg::MEM_ADDR_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire uep_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output uep_pkg::rsp_t      rsp
);

    uep_pkg::dp_cmd_t  dp_cmd;
    uep_pkg::dp_stat_t dp_stat;
    logic              push;
    uep_pkg::rsp_t     push_data;
    logic              skid_full;

    uep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .skid_full (skid_full),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    uep_dp #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (req.rx_byte),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .push      (push),
        .push_data (push_data)
    );

    uep_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .skid_full (skid_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench of the serial EEPROM page protocol engine.
module testbench;
    import uep_pkg::*;

    localparam int MEM_BYTES       = 1 << MEM_ADDR_BITS_DEF;
    localparam int MEM_MASK        = MEM_BYTES - 1;
    localparam int PAGES_IN_MEM    = MEM_BYTES / PAGE_BYTES;
    localparam int PAGES_PER_BLOCK = BLOCK_BYTES / PAGE_BYTES;
    localparam int BLOCKS_IN_MEM   = MEM_BYTES / BLOCK_BYTES;
    localparam int RANDOM_ITEMS    = 1850;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 150;

    localparam logic [7:0] OP_WRITE_4K = 8'h20;

    typedef enum logic [3:0] {
        PRED_IDLE,
        PRED_BLK_LO,
        PRED_BLK_HI,
        PRED_PAGE_LO,
        PRED_PAGE_HI,
        PRED_WR_LO,
        PRED_WR_HI,
        PRED_WR_DATA,
        PRED_WR_SUM,
        PRED_BAUD0,
        PRED_BAUD1,
        PRED_BAUD2,
        PRED_BAUD3,
        PRED_SENDING
    } engine_phase_t;

    class page_engine_scoreboard;
        engine_phase_t phase;
        logic [15:0]   number;
        logic [7:0]    sum;
        int            fill;
        logic [7:0]    page_buf [PAGE_BYTES];
        logic [7:0]    mem [MEM_BYTES];
        bit            known [MEM_BYTES];
        int            rd_ptr;
        int            rd_left;
        logic [31:0]   baud;
        rsp_t          expected_replies [$];
        int            mismatches;

        function new();
            phase      = PRED_IDLE;
            number     = '0;
            sum        = '0;
            fill       = 0;
            rd_ptr     = 0;
            rd_left    = 0;
            baud       = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function bit page_written(int idx);
            return known[idx * PAGE_BYTES];
        endfunction

        function int pick_written_page();
            int found [$];
            for (int p = 0; p < PAGES_IN_MEM; p++)
                if (page_written(p))
                    found.push_back(p);
            if (found.size() == 0)
                return -1;
            return found[$urandom_range(found.size() - 1)];
        endfunction

        function rsp_t begin_read(int base, int count, logic [7:0] header);
            rsp_t o;
            o         = '0;
            rd_ptr    = base & MEM_MASK;
            rd_left   = count;
            sum       = '0;
            phase     = PRED_SENDING;
            o.kind    = KIND_BYTE;
            o.tx_byte = header;
            return o;
        endfunction

        function void note_request(req_t item);
            rsp_t       o;
            bit         reply;
            logic [7:0] b;
            int         base;
            o     = '0;
            reply = 1'b0;
            b     = item.rx_byte;
            if (item.cmd == CMD_TX_PULL) begin
                if (phase == PRED_SENDING) begin
                    reply = 1'b1;
                    if (rd_left != 0) begin
                        o.tx_byte = mem[rd_ptr];
                        sum       = sum + mem[rd_ptr];
                        rd_ptr    = (rd_ptr + 1) & MEM_MASK;
                        rd_left--;
                    end
                    else begin
                        o.tx_byte = sum;
                        phase     = PRED_IDLE;
                    end
                end
            end
            else begin
                case (phase)
                    PRED_SENDING: ;
                    PRED_BAUD0:
                    begin
                        baud[7:0] = b;
                        phase     = PRED_BAUD1;
                    end
                    PRED_BAUD1:
                    begin
                        baud[15:8] = b;
                        phase      = PRED_BAUD2;
                    end
                    PRED_BAUD2:
                    begin
                        baud[23:16] = b;
                        phase       = PRED_BAUD3;
                    end
                    PRED_BAUD3:
                    begin
                        baud[31:24]  = b;
                        phase        = PRED_IDLE;
                        o.kind       = KIND_BAUD;
                        o.baud_value = baud;
                        reply        = 1'b1;
                    end
                    PRED_BLK_LO:
                    begin
                        number[7:0] = b;
                        phase       = PRED_BLK_HI;
                    end
                    PRED_PAGE_LO:
                    begin
                        number[7:0] = b;
                        phase       = PRED_PAGE_HI;
                    end
                    PRED_WR_LO:
                    begin
                        number[7:0] = b;
                        phase       = PRED_WR_HI;
                    end
                    PRED_BLK_HI:
                    begin
                        number[15:8] = b;
                        o = begin_read(int'(number) << BLOCK_SHIFT, BLOCK_BYTES, OP_BLOCK_READ);
                        reply = 1'b1;
                    end
                    PRED_PAGE_HI:
                    begin
                        number[15:8] = b;
                        o = begin_read(int'(number) << PAGE_IDX_W, PAGE_BYTES, OP_PAGE_READ);
                        reply = 1'b1;
                    end
                    PRED_WR_HI:
                    begin
                        number[15:8] = b;
                        sum          = '0;
                        fill         = 0;
                        phase        = PRED_WR_DATA;
                    end
                    PRED_WR_DATA:
                    begin
                        sum            = sum + b;
                        page_buf[fill] = b;
                        fill++;
                        if (fill == PAGE_BYTES)
                            phase = PRED_WR_SUM;
                    end
                    PRED_WR_SUM:
                    begin
                        phase = PRED_IDLE;
                        reply = 1'b1;
                        if (b == sum) begin
                            base = int'(number) << PAGE_IDX_W;
                            for (int i = 0; i < PAGE_BYTES; i++) begin
                                mem[(base + i) & MEM_MASK]   = page_buf[i];
                                known[(base + i) & MEM_MASK] = 1'b1;
                            end
                            o.tx_byte = OP_PAGE_WRITE;
                        end
                        else begin
                            o.tx_byte = OP_WRITE_NAK;
                        end
                    end
                    default:
                    begin
                        case (b)
                            OP_PING1, OP_PING2:
                            begin
                                o.tx_byte = b;
                                reply     = 1'b1;
                            end
                            OP_BLOCK_READ: phase = PRED_BLK_LO;
                            OP_PAGE_READ:  phase = PRED_PAGE_LO;
                            OP_PAGE_WRITE: phase = PRED_WR_LO;
                            OP_BAUD:       phase = PRED_BAUD0;
                            OP_RESET:
                            begin
                                o.kind = KIND_RESET;
                                reply  = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            if (reply)
                expected_replies.push_back(o);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("response with none expected: kind %0d byte %02h baud %08h",
                                          got.kind, got.tx_byte, got.baud_value));
                return;
            end
            want = expected_replies.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.tx_byte !== want.tx_byte)
                report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                          got.tx_byte, want.tx_byte));
            if (got.baud_value !== want.baud_value)
                report_mismatch($sformatf("baud_value %08h, expected %08h",
                                          got.baud_value, want.baud_value));
        endtask
    endclass

    logic  clk;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp;

    page_engine_scoreboard sb;

    int snd_idle_pct   = 16;
    int rcv_idle_pct   = 47;
    int sent_count     = 0;
    int pressure_asked = 0;
    int pressure_seen  = 0;
    int hold_left      = 0;

    uart_eeprom_page_protocol u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            sb.check_response(rsp);
        if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (pressure_seen != pressure_asked) begin
            pressure_seen++;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall == 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    task automatic send_item(input req_t item);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        sb.note_request(item);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        req_t item;
        item.cmd     = CMD_RX_BYTE;
        item.rx_byte = b;
        send_item(item);
    endtask

    task automatic send_pull();
        req_t item;
        item.cmd     = CMD_TX_PULL;
        item.rx_byte = 8'($urandom_range(255));
        send_item(item);
    endtask

    task automatic send_baud(input logic [31:0] v);
        send_byte(OP_BAUD);
        send_byte(v[7:0]);
        send_byte(v[15:8]);
        send_byte(v[23:16]);
        send_byte(v[31:24]);
    endtask

    task automatic write_page(input logic [15:0] pg, input bit good_sum, input bit with_pulls);
        logic [7:0] data;
        logic [7:0] total;
        send_byte(OP_PAGE_WRITE);
        send_byte(pg[7:0]);
        send_byte(pg[15:8]);
        total = '0;
        repeat (PAGE_BYTES) begin
            data = 8'($urandom_range(255));
            if (with_pulls && $urandom_range(9) == 0)
                send_pull();
            send_byte(data);
            total = total + data;
        end
        send_byte(good_sum ? total : total + 8'($urandom_range(255, 1)));
    endtask

    task automatic read_page(input logic [15:0] pg, input bit with_drops);
        send_byte(OP_PAGE_READ);
        send_byte(pg[7:0]);
        send_byte(pg[15:8]);
        repeat (PAGE_BYTES + 1) begin
            if (with_drops && $urandom_range(7) == 0)
                send_byte(8'($urandom_range(255)));
            send_pull();
        end
    endtask

    function automatic logic [15:0] page_alias(int idx);
        return 16'($urandom_range(65535 / PAGES_IN_MEM) * PAGES_IN_MEM + idx);
    endfunction

    initial
    begin
        int          start;
        int          progress;
        int          sel;
        int          idx;
        int          cnt;
        int          best;
        int          blk_pick;
        logic [15:0] pg;
        logic [7:0]  b;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pull();
        send_byte(8'h00);
        send_byte(OP_WRITE_4K);
        send_byte(8'hff);
        send_byte(OP_PING1);
        send_byte(OP_PING2);
        send_byte(OP_RESET);
        send_baud(32'h0000_0000);
        send_baud(32'hffff_ffff);
        send_baud(32'h1234_5678);
        pressure_asked++;
        repeat (3) begin
            send_byte(OP_PING1);
            send_byte(OP_PING2);
        end

        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            progress = sent_count - start;
            if (progress < RANDOM_ITEMS / 3) begin
                snd_idle_pct = 16;
                rcv_idle_pct = 47;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3) begin
                snd_idle_pct = 47;
                rcv_idle_pct = 16;
            end
            else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            sel = $urandom_range(99);
            idx = sb.pick_written_page();
            if (sel < 35 || (sel < 55 && idx < 0)) begin
                if ($urandom_range(7) == 0)
                    pg = $urandom_range(1) ? 16'hffff : 16'h0000;
                else
                    pg = 16'($urandom_range(65535));
                write_page(pg, $urandom_range(99) < 85, $urandom_range(3) == 0);
            end
            else if (sel < 55) begin
                read_page(page_alias(idx), $urandom_range(1));
            end
            else if (sel < 65) begin
                case ($urandom_range(2))
                    0:       send_byte(OP_PING1);
                    1:       send_byte(OP_PING2);
                    default: send_byte(OP_RESET);
                endcase
            end
            else if (sel < 75) begin
                send_baud($urandom);
            end
            else begin
                repeat ($urandom_range(8, 1)) begin
                    if ($urandom_range(1)) begin
                        send_pull();
                    end
                    else begin
                        b = 8'($urandom_range(255));
                        if (b == OP_BLOCK_READ || b == OP_PAGE_READ || b == OP_PAGE_WRITE ||
                            b == OP_BAUD)
                            b = OP_WRITE_4K;
                        send_byte(b);
                    end
                end
            end
        end

        // Complete whichever block is nearest to fully written, then read it back whole.
        best     = -1;
        blk_pick = 0;
        for (int k = 0; k < BLOCKS_IN_MEM; k++) begin
            cnt = 0;
            for (int p = 0; p < PAGES_PER_BLOCK; p++)
                if (sb.page_written(k * PAGES_PER_BLOCK + p))
                    cnt++;
            if (cnt > best) begin
                best     = cnt;
                blk_pick = k;
            end
        end
        for (int p = 0; p < PAGES_PER_BLOCK; p++) begin
            idx = blk_pick * PAGES_PER_BLOCK + p;
            if (!sb.page_written(idx))
                write_page(page_alias(idx), 1'b1, 1'b0);
        end
        if (blk_pick == BLOCKS_IN_MEM - 1 && $urandom_range(1))
            pg = 16'hffff;
        else
            pg = 16'($urandom_range(65535 / BLOCKS_IN_MEM) * BLOCKS_IN_MEM + blk_pick);
        send_byte(OP_BLOCK_READ);
        send_byte(pg[7:0]);
        send_byte(pg[15:8]);
        repeat (BLOCK_BYTES + 1) begin
            if ($urandom_range(63) == 0)
                send_byte(8'($urandom_range(255)));
            send_pull();
        end
        send_pull();

        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
